>>> src/gmb_pkg.sv
// ============================================================================
// gmb_pkg: shared types and constants for the glyph mask blitter
// Holds the coordinate and address sizes, the transaction payloads, and the
// structs that pass between the pixel lanes, the merge stage and the emitter.
// ============================================================================
package gmb_pkg;

  localparam int COORD_BITS   = 16;
  localparam int ADDRESS_BITS = 32;

  localparam int LANES    = 8;
  localparam int LANE_W   = $clog2(LANES);
  localparam int CFG_W    = 16;
  localparam int COL_W    = 16;
  localparam int OUT_AW   = 32;
  // signed working width for columns and rows, room for the lane offset
  localparam int PX_W     = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;
  localparam int EFF_AW   = (ADDRESS_BITS < OUT_AW) ? ADDRESS_BITS : OUT_AW;
  localparam logic [OUT_AW-1:0] ADDR_MASK = OUT_AW'((64'd1 << EFF_AW) - 64'd1);

  // register indexes
  localparam logic [2:0] REG_DEST_WIDTH  = 3'd0;
  localparam logic [2:0] REG_DEST_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LINE_BYTES  = 3'd2;
  localparam logic [2:0] REG_DEPTH_CODE  = 3'd3;
  localparam logic [2:0] REG_DOT_PATTERN = 3'd4;
  localparam logic [2:0] REG_DRAW_BLACK  = 3'd5;
  localparam logic [2:0] REG_USE_COLOR   = 3'd6;

  // depth codes; the fourth code draws nothing
  localparam logic [1:0] DEPTH_1BPP = 2'd0;
  localparam logic [1:0] DEPTH_2BPP = 2'd1;
  localparam logic [1:0] DEPTH_8BPP = 2'd2;
  localparam logic [1:0] DEPTH_NONE = 2'd3;

  localparam logic [7:0] MASK_1BPP  = 8'h80;
  localparam logic [2:0] MASK_BIT   = 3'h7;
  localparam logic [7:0] FIELD_2BPP = 8'h03 << 6;
  localparam logic [1:0] MASK_FIELD = 2'h3;
  localparam logic [7:0] MASK_FULL  = 8'hff;

  typedef struct packed {
    logic [7:0]                   glyph_bits;
    logic signed [COORD_BITS-1:0] dest_x;
    logic signed [COORD_BITS-1:0] dest_y;
    logic [3:0]                   valid_bits;
  } in_item_t;

  typedef struct packed {
    logic [OUT_AW-1:0] byte_address;
    logic [7:0]        bit_mask;
    logic [7:0]        write_data;
    logic              from_color;
    logic              last_write;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       depth;
    logic [1:0]       dot;
    logic             black;
    logic             color;
    logic [CFG_W-1:0] width;
  } lane_cfg_t;

  typedef struct packed {
    logic             pix;
    logic [COL_W-1:0] col;
    logic [7:0]       mask;
    logic [7:0]       data;
  } lane_t;

  typedef struct packed {
    logic [LANES-1:0]             slot;
    logic [LANES-1:0][OUT_AW-1:0] addr;
    logic [LANES-1:0][7:0]        mask;
    logic [LANES-1:0][7:0]        data;
    logic                         color;
  } wset_t;

endpackage

>>> src/gmb_lane.sv
// ============================================================================
// gmb_lane: one pixel lane
// Places one glyph pixel: clips it against the raster width and works out
// its destination byte column, bit mask and data for the current depth.
// ============================================================================
module gmb_lane
  import gmb_pkg::*;
(
  input  logic                         enable,
  input  logic                         glyph_bit,
  input  logic signed [COORD_BITS-1:0] dest_x,
  input  logic [LANE_W-1:0]            lane_idx,
  input  lane_cfg_t                    cfg,
  output lane_t                        lane
);

  logic signed [PX_W-1:0] px;
  logic                   in_raster;
  logic [COL_W-1:0]       p;
  logic [2:0]             sh;
  logic [7:0]             m;
  logic [COL_W-1:0]       col;
  logic                   depth_ok;

  assign px = $signed({{(PX_W-COORD_BITS){dest_x[COORD_BITS-1]}}, dest_x})
            + $signed({{(PX_W-LANE_W){1'b0}}, lane_idx});
  assign in_raster = (px >= 0) && (px < $signed({{(PX_W-CFG_W){1'b0}}, cfg.width}));
  assign p  = px[COL_W-1:0];
  assign sh = {p[1:0] & MASK_FIELD, 1'b0};

  always_comb begin
    depth_ok = 1'b1;
    unique case (cfg.depth)
      DEPTH_1BPP: begin
        col = p >> 3;
        m   = MASK_1BPP >> (p[2:0] & MASK_BIT);
      end
      DEPTH_2BPP: begin
        col = p >> 2;
        m   = (cfg.color ? FIELD_2BPP : {cfg.dot, 6'b0}) >> sh;
      end
      DEPTH_8BPP: begin
        col = p;
        m   = MASK_FULL;
      end
      default: begin
        depth_ok = 1'b0;
        col      = '0;
        m        = '0;
      end
    endcase
  end

  assign lane.pix  = enable && glyph_bit && in_raster && depth_ok;
  assign lane.col  = col;
  assign lane.mask = m;
  assign lane.data = (cfg.black && !cfg.color) ? m : 8'h00;

endmodule

>>> src/gmb_merge.sv
// ============================================================================
// gmb_merge: lane merge
// Groups lanes that hit the same destination byte, ORs their masks and data,
// and forms the byte address of each group at its leftmost lane.
// ============================================================================
module gmb_merge
  import gmb_pkg::*;
(
  input  lane_t [LANES-1:0]  lanes,
  input  logic [OUT_AW-1:0]  row_base,
  input  logic               color,
  output wset_t              wset
);

  logic [LANES-1:0][LANES-1:0] same;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        same[i][j] = lanes[j].pix && (lanes[j].col == lanes[i].col);
      end
    end
  end

  always_comb begin
    logic first;
    logic [7:0] m;
    logic [7:0] d;
    wset.color = color;
    for (int i = 0; i < LANES; i++) begin
      first = lanes[i].pix;
      m = '0;
      d = '0;
      for (int j = 0; j < LANES; j++) begin
        if (j < i && same[i][j]) first = 1'b0;
        if (same[i][j]) begin
          m = m | lanes[j].mask;
          d = d | lanes[j].data;
        end
      end
      // drop groups whose mask is empty (blank dot pattern)
      wset.slot[i] = first && (m != 8'h00);
      wset.mask[i] = m;
      wset.data[i] = d;
      wset.addr[i] = (row_base + {{(OUT_AW-COL_W){1'b0}}, lanes[i].col}) & ADDR_MASK;
    end
  end

endmodule

>>> src/gmb_emit.sv
// ============================================================================
// gmb_emit: write emitter
// Holds the merged write set of one glyph byte and sends its writes one per
// cycle unless stalled, lowest lane first, flagging the final one.
// ============================================================================
module gmb_emit
  import gmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      set_valid,
  input  wset_t     set_in,
  output logic      set_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [LANES-1:0] slot_r, slot_nxt;
  wset_t            set_r;
  logic [LANES-1:0] lowest;
  logic [LANES-1:0] remaining;
  logic [LANE_W-1:0] sel;
  logic             fire;
  logic             last;

  assign lowest    = slot_r & (~slot_r + LANES'(1));
  assign remaining = slot_r & ~lowest;
  assign last      = (remaining == '0);
  assign out_valid = (slot_r != '0);
  assign fire      = out_valid && !out_stall;
  assign set_take  = !out_valid || (fire && last);

  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (slot_r[i]) sel = LANE_W'(i);
    end
  end

  always_comb begin
    out_item.byte_address = set_r.addr[sel];
    out_item.bit_mask     = set_r.mask[sel];
    out_item.write_data   = set_r.data[sel];
    out_item.from_color   = set_r.color;
    out_item.last_write   = last;
  end

  always_comb begin
    slot_nxt = slot_r;
    if (set_take) begin
      slot_nxt = set_valid ? set_in.slot : '0;
    end else if (fire) begin
      slot_nxt = remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (set_take && set_valid) begin
      set_r <= set_in;
    end
  end

`ifndef SYNTHESIS
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !out_item.last_write |=> out_valid)
    else $error("write set ended without a last write");
  a_mask_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.bit_mask != 8'h00)
    else $error("write with empty mask");
  a_data_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.write_data & ~out_item.bit_mask) == 8'h00)
    else $error("data outside mask");
  a_color_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.from_color |-> out_item.write_data == 8'h00)
    else $error("colour-plane write carries data");
`endif

endmodule

>>> src/glyph_mask_blit.sv
// ============================================================================
// glyph_mask_blit: monochrome glyph byte to masked raster byte writes
// Clips eight glyph pixels against the raster and emits merged byte writes.
// ============================================================================
// Each accepted glyph byte passes through eight pixel lanes and a row-address
// multiply, is registered, then merged into at most eight byte writes that
// leave one per cycle unless the output stalls, in rising column order, the
// last one flagged. A glyph byte causes one or two writes at 1 bpp, up to
// three at 2 bpp, up to eight at 8 bpp, and none when fully clipped. The
// emitter, sending one write a cycle unless stalled, sets the rate; the next
// byte is taken in the cycle the final write of the previous one goes out. An
// input transaction is registered in stage 1 and again in the emitter before
// its first write appears. Configure only while idle.
// ============================================================================
module glyph_mask_blit
  import gmb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] width_r, height_r, stride_r;
  logic [1:0]       depth_r, dot_r;
  logic             black_r, color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(1);
      height_r <= CFG_W'(1);
      stride_r <= CFG_W'(1);
      depth_r  <= DEPTH_1BPP;
      dot_r    <= 2'd3;
      black_r  <= 1'b1;
      color_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:  width_r  <= cfg_wdata;
        REG_DEST_HEIGHT: height_r <= cfg_wdata;
        REG_LINE_BYTES:  stride_r <= cfg_wdata;
        REG_DEPTH_CODE:  depth_r  <= cfg_wdata[1:0];
        REG_DOT_PATTERN: dot_r    <= cfg_wdata[1:0];
        REG_DRAW_BLACK:  black_r  <= cfg_wdata[0];
        REG_USE_COLOR:   color_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  lane_cfg_t lane_cfg;
  logic      color_mode;

  assign color_mode     = (depth_r == DEPTH_2BPP) && color_r;
  assign lane_cfg.depth = depth_r;
  assign lane_cfg.dot   = dot_r;
  assign lane_cfg.black = black_r;
  assign lane_cfg.color = color_mode;
  assign lane_cfg.width = width_r;

  logic signed [PX_W-1:0] y_ext;
  logic                   row_ok;
  logic [OUT_AW-1:0]      row_base;
  lane_t [LANES-1:0]      lane_d;

  assign y_ext  = $signed({{(PX_W-COORD_BITS){in_item.dest_y[COORD_BITS-1]}},
                           in_item.dest_y});
  assign row_ok = (y_ext >= 0) && (y_ext < $signed({{(PX_W-CFG_W){1'b0}}, height_r}));
  assign row_base = OUT_AW'(y_ext[CFG_W-1:0]) * OUT_AW'(stride_r);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    gmb_lane u_lane (
      .enable    (row_ok && ({1'b0, LANE_W'(i)} < 4'(in_item.valid_bits))),
      .glyph_bit (in_item.glyph_bits[LANES-1-i]),
      .dest_x    (in_item.dest_x),
      .lane_idx  (LANE_W'(i)),
      .cfg       (lane_cfg),
      .lane      (lane_d[i])
    );
  end

  // stage 1: lane results and row base
  logic              s1_valid_r, s1_valid_nxt;
  lane_t [LANES-1:0] lane_r;
  logic [OUT_AW-1:0] row_base_r;
  logic              color_s1_r;
  logic              in_accept;
  logic              set_take;
  wset_t             wset;

  assign in_stall  = s1_valid_r && !set_take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (set_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      lane_r     <= lane_d;
      row_base_r <= row_base;
      color_s1_r <= color_mode;
    end
  end

  gmb_merge u_merge (
    .lanes    (lane_r),
    .row_base (row_base_r),
    .color    (color_s1_r),
    .wset     (wset)
  );

  gmb_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_valid (s1_valid_r),
    .set_in    (wset),
    .set_take  (set_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> tb/sv/tb_glyph_mask_blit.sv
// ============================================================================
// tb_glyph_mask_blit: self-checking bench for the glyph mask blitter
// Drives glyph bytes under changing raster settings, predicts the merged
// masked byte writes each one causes, and checks every write field by field.
// ============================================================================
module tb_glyph_mask_blit;
  import gmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 6;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] stride;
    logic [1:0]       depth;
    logic [1:0]       dot;
    logic             black;
    logic             color;
  } blit_cfg_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = REG_DEST_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  blit_cfg_t cur_cfg = '{16'd1, 16'd1, 16'd1, DEPTH_1BPP, 2'd3, 1'b1, 1'b0};
  out_item_t pending_writes[$];
  int errors = 0;
  int glyphs_accepted = 0;
  int writes_checked = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int tx_gap_max = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;
  int rx_hold_left = 0;

  glyph_mask_blit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected writes for one glyph byte under the current settings.
  function automatic void predict_writes(in_item_t g);
    out_item_t   wr[8];
    int          n, nvalid, px, y, i, k;
    logic [63:0] row_base;
    logic [31:0] col, cur_col;
    logic [7:0]  m, d, cur_mask, cur_data;
    logic        pix, have, color;
    color = (cur_cfg.depth == DEPTH_2BPP) && cur_cfg.color;
    nvalid = (g.valid_bits > 4'd8) ? 8 : int'(g.valid_bits);
    y = int'($signed(g.dest_y));
    if (cur_cfg.depth == DEPTH_NONE) return;
    if (y < 0 || y >= int'(cur_cfg.height)) return;
    row_base = 64'(y) * 64'(cur_cfg.stride);
    n = 0;
    have = 1'b0;
    cur_col = '0;
    cur_mask = '0;
    cur_data = '0;
    for (i = 0; i <= nvalid; i++) begin
      pix = 1'b0;
      col = '0;
      m = '0;
      d = '0;
      if (i < nvalid && g.glyph_bits[7-i]) begin
        px = int'($signed(g.dest_x)) + i;
        if (px >= 0 && px < int'(cur_cfg.width)) begin
          pix = 1'b1;
          case (cur_cfg.depth)
            DEPTH_1BPP: begin
              col = 32'(px / 8);
              m = MASK_1BPP >> (px % 8);
            end
            DEPTH_2BPP: begin
              col = 32'(px / 4);
              m = (color ? FIELD_2BPP : {cur_cfg.dot, 6'b0}) >> (2 * (px % 4));
            end
            default: begin
              col = 32'(px);
              m = MASK_FULL;
            end
          endcase
          d = (cur_cfg.black && !color) ? m : 8'h00;
        end
      end
      // close the open byte at the end or when the column byte moves on
      if (have && (i == nvalid || (pix && col != cur_col))) begin
        if (cur_mask != 8'h00) begin
          wr[n].byte_address = 32'(row_base + 64'(cur_col));
          wr[n].bit_mask = cur_mask;
          wr[n].write_data = cur_data;
          wr[n].from_color = color;
          wr[n].last_write = 1'b0;
          n++;
        end
        have = 1'b0;
      end
      if (pix) begin
        if (!have) begin
          have = 1'b1;
          cur_col = col;
          cur_mask = '0;
          cur_data = '0;
        end
        cur_mask |= m;
        cur_data |= d;
      end
    end
    for (k = 0; k < n; k++) begin
      wr[k].last_write = (k == n - 1);
      pending_writes.push_back(wr[k]);
    end
  endfunction

  function automatic in_item_t glyph(logic [7:0] b, int x, int y, int n);
    in_item_t g;
    g.glyph_bits = b;
    g.dest_x = 16'(x);
    g.dest_y = 16'(y);
    g.valid_bits = 4'(n);
    return g;
  endfunction

  // Mostly near the raster so pixels land; now and then anywhere at all.
  function automatic in_item_t rand_glyph();
    in_item_t g;
    int span_x, span_y;
    span_x = (cur_cfg.width > 16'd32000) ? 32000 : int'(cur_cfg.width);
    span_y = (cur_cfg.height > 16'd32000) ? 32000 : int'(cur_cfg.height);
    g.glyph_bits = ($urandom_range(5) == 0) ? 8'hff : 8'($urandom);
    g.valid_bits = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8, 1));
    if ($urandom_range(7) == 0) begin
      g.dest_x = 16'($urandom);
      g.dest_y = 16'($urandom);
    end else begin
      g.dest_x = 16'(int'($urandom_range(span_x + 16)) - 8);
      g.dest_y = 16'(int'($urandom_range(span_y + 2)) - 1);
    end
    return g;
  endfunction

  task automatic send_glyph(in_item_t g);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(tx_gap_max);
      burst_left = $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    // a fully clipped byte may still be in flight with nothing to show
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apply_config(blit_cfg_t c);
    logic [CFG_W-1:0] vals[7];
    wait_idle();
    vals[REG_DEST_WIDTH]  = c.width;
    vals[REG_DEST_HEIGHT] = c.height;
    vals[REG_LINE_BYTES]  = c.stride;
    vals[REG_DEPTH_CODE]  = CFG_W'(c.depth);
    vals[REG_DOT_PATTERN] = CFG_W'(c.dot);
    vals[REG_DRAW_BLACK]  = CFG_W'(c.black);
    vals[REG_USE_COLOR]   = CFG_W'(c.color);
    for (int r = 0; r < 7; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(r);
      cfg_wdata <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Input monitor: every accepted transaction feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      glyphs_accepted++;
      predict_writes(in_item);
    end
  end

  // Output checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual addr %0h mask %0h data %0h",
                 $time, out_item.byte_address, out_item.bit_mask, out_item.write_data);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        check_field("byte_address", want.byte_address, out_item.byte_address);
        check_field("bit_mask", 32'(want.bit_mask), 32'(out_item.bit_mask));
        check_field("write_data", 32'(want.write_data), 32'(out_item.write_data));
        check_field("from_color", 32'(want.from_color), 32'(out_item.from_color));
        check_field("last_write", 32'(want.last_write), 32'(out_item.last_write));
      end
    end
  end

  // Receiver: a long hold on request, otherwise random stalls at a set rate.
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= rst_n && (int'($urandom_range(99)) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    tx_gap_max = 2;
    rx_stall_pct = 25;
    apply_config('{16'd20, 16'd4, 16'd3, DEPTH_1BPP, 2'd3, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 0, 0, 8));
    send_glyph(glyph(8'hff, 5, 1, 8));            // straddles two bytes
    send_glyph(glyph(8'hff, -3, 2, 8));           // left edge clip
    send_glyph(glyph(8'hff, 16, 3, 8));           // right edge clip
    send_glyph(glyph(8'ha5, 2, 0, 5));
    send_glyph(glyph(8'hff, 0, 0, 0));            // no valid bits
    send_glyph(glyph(8'hff, 8, 1, 15));           // count above eight
    send_glyph(glyph(8'hff, 0, -1, 8));
    send_glyph(glyph(8'hff, 0, 4, 8));
    send_glyph(glyph(8'h80, -32768, 0, 8));
    send_glyph(glyph(8'h01, 32767, 3, 8));
    send_glyph(glyph(8'hff, 0, -32768, 8));
    apply_config('{16'd20, 16'd4, 16'd3, DEPTH_1BPP, 2'd3, 1'b0, 1'b0});
    send_glyph(glyph(8'hf0, 3, 1, 8));
    apply_config('{16'd20, 16'd4, 16'd5, DEPTH_2BPP, 2'd2, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 1, 0, 8));
    send_glyph(glyph(8'h3c, -1, 2, 8));
    apply_config('{16'd20, 16'd4, 16'd5, DEPTH_2BPP, 2'd0, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 0, 0, 8));            // empty dot, nothing written
    apply_config('{16'd20, 16'd4, 16'd5, DEPTH_2BPP, 2'd1, 1'b1, 1'b1});
    send_glyph(glyph(8'hff, 2, 1, 8));
    send_glyph(glyph(8'h81, 0, 3, 8));
    apply_config('{16'd20, 16'd4, 16'd20, DEPTH_8BPP, 2'd3, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 14, 0, 8));
    apply_config('{16'd20, 16'd4, 16'd20, DEPTH_8BPP, 2'd3, 1'b0, 1'b1});
    send_glyph(glyph(8'hc3, -2, 1, 8));           // color plane ignored here
    apply_config('{16'd20, 16'd4, 16'd20, DEPTH_NONE, 2'd3, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 0, 0, 8));
    apply_config('{16'd0, 16'd4, 16'd3, DEPTH_1BPP, 2'd3, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 0, 0, 8));
    apply_config('{16'd20, 16'd0, 16'd3, DEPTH_1BPP, 2'd3, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 0, 0, 8));
    apply_config('{16'd20, 16'd4, 16'd0, DEPTH_1BPP, 2'd3, 1'b1, 1'b0});
    send_glyph(glyph(8'hff, 9, 3, 8));            // address is column byte only
  endtask

  task automatic test_config_extremes();
    tx_gap_max = 0;
    rx_stall_pct = 0;
    apply_config('{16'hffff, 16'hffff, 16'hffff, DEPTH_8BPP, 2'd3, 1'b1, 1'b1});
    repeat (20) send_glyph(rand_glyph());
    apply_config('{16'd1, 16'd1, 16'd1, DEPTH_1BPP, 2'd3, 1'b1, 1'b0});
    repeat (10) send_glyph(rand_glyph());
  endtask

  task automatic test_random_settings();
    blit_cfg_t c;
    int knob;
    for (int p = 0; p < 11; p++) begin
      c.width  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(80));
      c.height = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(12));
      c.stride = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      c.depth  = ($urandom_range(9) == 0) ? DEPTH_NONE : 2'($urandom_range(2));
      c.dot    = 2'($urandom);
      c.black  = 1'($urandom);
      c.color  = 1'($urandom);
      knob = $urandom_range(2);
      tx_gap_max = (knob == 0) ? 0 : (knob == 1) ? 2 : 10;
      knob = $urandom_range(2);
      rx_stall_pct = (knob == 0) ? 0 : (knob == 1) ? 30 : 70;
      apply_config(c);
      repeat (28) send_glyph(rand_glyph());
    end
  endtask

  // Hold the output off for a long stretch while 8 bpp bytes keep coming.
  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_stall_pct = 0;
    apply_config('{16'd256, 16'd8, 16'd256, DEPTH_8BPP, 2'd3, 1'b1, 1'b0});
    rx_hold_req = 200;
    repeat (24) send_glyph(glyph(8'hff, $urandom_range(200), $urandom_range(7), 8));
    rx_stall_pct = 40;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random_settings();
    test_backpressure();
    wait_idle();
    if (pending_writes.size() != 0) begin
      $display("%0t: %0d expected writes never arrived", $time, pending_writes.size());
      errors += pending_writes.size();
    end
    $display("Covered %0d glyph bytes and %0d checked byte writes over %0d register settings,",
             glyphs_accepted, writes_checked, settings_used);
    $display("including all depths, clipping on every edge and a long output hold.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
